@@ rtl/core/lte_scr_pkg.sv @@
// Package: shared types, constants and the 32-bit Gold sequence advance.
`timescale 1ns / 1ps
package lte_scr_pkg;

   localparam int MAX_WORDS  = 256;
   localparam int WORD_BITS  = 32;
   localparam int LFSR_BITS  = 31;
   localparam int WCNT_BITS  = $clog2(MAX_WORDS + 1);
   localparam int INDEX_SAT  = 255;

   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_CHANNEL_KIND   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CELL_GROUP     = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CELL_SECTOR    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RADIO_TEMP_ID  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CODEWORD_INDEX = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MBSFN_AREA_ID  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LEAD_IN_WORDS  = 3'd6;

   // channel kinds
   localparam logic [2:0] CH_SHARED    = 3'd0;
   localparam logic [2:0] CH_FORMAT    = 3'd1;
   localparam logic [2:0] CH_CONTROL   = 3'd2;
   localparam logic [2:0] CH_BROADCAST = 3'd3;
   localparam logic [2:0] CH_MULTICAST = 3'd4;
   localparam logic [2:0] CH_UL_CTRL   = 3'd5;

   // request modes
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_NEXT  = 1'b1;

   localparam logic [5:0] LEAD_IN_RESET = 6'd50;

   typedef logic [LFSR_BITS-1:0] lfsr_type;

   typedef struct packed {
      lfsr_type              x1;
      lfsr_type              x2;
      logic [WORD_BITS-1:0]  word;
   } adv_type;

   // Steps both registers by one word; bit k of word is the k-th output bit.
   function automatic adv_type advance_word(input lfsr_type x1, input lfsr_type x2);
      adv_type  res;
      lfsr_type a;
      lfsr_type b;
      logic     na;
      logic     nb;
      a = x1;
      b = x2;
      for (int k = 0; k < WORD_BITS; k++) begin
         res.word[k] = a[0] ^ b[0];
         na = a[3] ^ a[0];
         nb = b[3] ^ b[2] ^ b[1] ^ b[0];
         a  = {na, a[LFSR_BITS-1:1]};
         b  = {nb, b[LFSR_BITS-1:1]};
      end
      res.x1 = a;
      res.x2 = b;
      return res;
   endfunction

endpackage

@@ rtl/core/lte_scrambling_sequence_generator.sv @@
// Top level: LTE Gold scrambling sequence generator, 32 bits per word.
`timescale 1ns / 1ps
// Gives the LTE length-31 Gold scrambling sequence one 32-bit word at a time, earliest
// bit in bit 0. A request with tuser low (start) seeds x1 with 1 and x2 with c_init,
// formed from the configured channel kind, cell identity, RNTI, codeword and MBSFN
// area plus the subframe in tdata[3:0]; it then discards lead_in_words whole words and
// gives no response. A start occupies the block while the lead-in words (up to 63) are
// discarded by the single 32-bit advance unit stepping once per cycle; req_tready is low while
// it runs. A request with tuser high (next) gives one response:
// seq_word in tdata[31:0], the word's position since the last start in tdata[39:32]
// (saturating at 255) and tuser high once that position reaches MAX_WORDS. The response
// sits in an output register, so a new request is taken in the cycle it is drained.
// A next before any start runs on from the reset registers. Configuration writes are
// always accepted and must only be made while the block is idle.
module lte_scrambling_sequence_generator (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [7:0]                             req_tdata,   // [3:0] subframe, rest zero
   input  logic                                   req_tuser,   // [0] mode
   // response channel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [39:0]                            rsp_tdata,   // [31:0] seq_word,
                                                               // [39:32] word_index
   output logic                                   rsp_tuser,   // [0] past_limit
   // configuration write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [lte_scr_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [lte_scr_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import lte_scr_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SKIP = 1'b1;

   // configuration
   logic [2:0]  channel_kind_ff;
   logic [7:0]  cell_group_ff;
   logic [1:0]  cell_sector_ff;
   logic [15:0] radio_temp_id_ff;
   logic        codeword_index_ff;
   logic [7:0]  mbsfn_area_id_ff;
   logic [5:0]  lead_in_words_ff;

   // sequencer and sequence state
   logic                 state_ff, state_in;
   logic [5:0]           skip_cnt_ff, skip_cnt_in;
   lfsr_type             x1_ff, x1_in;
   lfsr_type             x2_ff, x2_in;
   logic [WCNT_BITS-1:0] words_given_ff, words_given_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_word_ff;
   logic [7:0]           rsp_index_ff;
   logic                 rsp_past_ff;

   adv_type     adv;
   logic        req_acc;
   logic        start_acc;
   logic        next_acc;
   logic [3:0]  subframe;
   logic [9:0]  n_cell;
   logic [15:0] seed_prod;
   logic [31:0] seed_full;
   logic [7:0]  index_sat;

   assign csr_ready = 1'b1;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_acc    = req_tvalid && req_tready;
   assign start_acc  = req_acc && (req_tuser == MODE_START);
   assign next_acc   = req_acc && (req_tuser == MODE_NEXT);
   assign subframe   = req_tdata[3:0];

   // the one shared advance unit
   assign adv = advance_word(x1_ff, x2_ff);

   // c_init
   assign n_cell    = 10'({cell_group_ff, 1'b0}) + 10'(cell_group_ff) + 10'(cell_sector_ff);
   assign seed_prod = 16'(5'(subframe) + 5'd1) * 16'({n_cell, 1'b1});

   always_comb begin
      unique case (channel_kind_ff)
         CH_SHARED:    seed_full = (32'(radio_temp_id_ff) << 14)
                                   + (32'(codeword_index_ff) << 13)
                                   + (32'(subframe) << 9) + 32'(n_cell);
         CH_FORMAT:    seed_full = (32'(seed_prod) << 9) + 32'(n_cell);
         CH_CONTROL:   seed_full = (32'(subframe) << 9) + 32'(n_cell);
         CH_BROADCAST: seed_full = 32'(n_cell);
         CH_MULTICAST: seed_full = (32'(subframe) << 9) + 32'(mbsfn_area_id_ff);
         CH_UL_CTRL:   seed_full = (32'(seed_prod) << 16) + 32'(radio_temp_id_ff);
         default:      seed_full = '0;
      endcase
   end

   assign index_sat = (words_given_ff > WCNT_BITS'(INDEX_SAT)) ? 8'(INDEX_SAT)
                                                               : 8'(words_given_ff);

   always_comb begin
      state_in       = state_ff;
      skip_cnt_in    = skip_cnt_ff;
      x1_in          = x1_ff;
      x2_in          = x2_ff;
      words_given_in = words_given_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      priority if (state_ff == ST_SKIP) begin
         x1_in       = adv.x1;
         x2_in       = adv.x2;
         skip_cnt_in = skip_cnt_ff - 6'd1;
         if (skip_cnt_ff == 6'd1) begin
            state_in = ST_IDLE;
         end
      end else if (start_acc) begin
         x1_in          = lfsr_type'(1);
         x2_in          = seed_full[LFSR_BITS-1:0];
         words_given_in = '0;
         skip_cnt_in    = lead_in_words_ff;
         state_in       = (lead_in_words_ff == 6'd0) ? ST_IDLE : ST_SKIP;
      end else if (next_acc) begin
         x1_in        = adv.x1;
         x2_in        = adv.x2;
         rsp_valid_in = 1'b1;
         if (words_given_ff < WCNT_BITS'(MAX_WORDS)) begin
            words_given_in = words_given_ff + WCNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         skip_cnt_ff    <= '0;
         x1_ff          <= lfsr_type'(1);
         x2_ff          <= '0;
         words_given_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         skip_cnt_ff    <= skip_cnt_in;
         x1_ff          <= x1_in;
         x2_ff          <= x2_in;
         words_given_ff <= words_given_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // response payload, loaded with the word just generated
   always_ff @(posedge clock) begin
      if (next_acc) begin
         rsp_word_ff  <= adv.word;
         rsp_index_ff <= index_sat;
         rsp_past_ff  <= (words_given_ff >= WCNT_BITS'(MAX_WORDS));
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_kind_ff   <= CH_SHARED;
         cell_group_ff     <= '0;
         cell_sector_ff    <= '0;
         radio_temp_id_ff  <= '0;
         codeword_index_ff <= 1'b0;
         mbsfn_area_id_ff  <= '0;
         lead_in_words_ff  <= LEAD_IN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CHANNEL_KIND:   channel_kind_ff   <= csr_data[2:0];
            CSR_CELL_GROUP:     cell_group_ff     <= csr_data[7:0];
            CSR_CELL_SECTOR:    cell_sector_ff    <= csr_data[1:0];
            CSR_RADIO_TEMP_ID:  radio_temp_id_ff  <= csr_data[15:0];
            CSR_CODEWORD_INDEX: codeword_index_ff <= csr_data[0];
            CSR_MBSFN_AREA_ID:  mbsfn_area_id_ff  <= csr_data[7:0];
            CSR_LEAD_IN_WORDS:  lead_in_words_ff  <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_index_ff, rsp_word_ff};
   assign rsp_tuser  = rsp_past_ff;

   // x1 starts from one and is maximal length, so it never locks up at zero
   a_x1_nonzero: assert property (@(posedge clock) disable iff (reset)
      x1_ff != '0) else $error("x1 register reached zero");

   // no request is taken while lead-in words are being discarded
   a_skip_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SKIP) |-> !req_tready) else $error("ready during lead-in");

   // every accepted next request leaves a response in the output register
   a_next_rsp: assert property (@(posedge clock) disable iff (reset)
      next_acc |=> rsp_tvalid) else $error("next request gave no response");

   // a start clears the word count
   a_start_clr: assert property (@(posedge clock) disable iff (reset)
      start_acc |=> (words_given_ff == '0)) else $error("word count not cleared");

endmodule

@@ tb/tb_lte_scrambling_sequence_generator.sv @@
// Testbench for the LTE Gold scrambling sequence generator: self-checking, with stalls.
`timescale 1ns / 1ps
module tb_lte_scrambling_sequence_generator;
   import lte_scr_pkg::*;

   // Cycles with no handshake on any channel before the run is declared hung.
   // A start's lead-in, the long receiver hold-off and the settle after each phase
   // all fall far short of the limit, so this leaves ample margin.
   localparam int IDLE_LIMIT   = 5000;
   localparam int SETTLE_WAIT  = 70;    // covers the longest lead-in
   localparam int SQUEEZE_LEN  = 300;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 3'd7;

   typedef struct {
      logic       mode;
      logic [3:0] subframe;
   } seq_req_type;

   typedef struct {
      logic [31:0] word;
      logic [7:0]  index;
      logic        past;
   } gold_word_type;

   // ---------------------------------------------------------------------------------
   // DUT connections; every input is known from time zero
   // ---------------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;          // [3:0] subframe, [7:4] zero
   logic        req_tuser = 1'b0;        // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;               // [31:0] seq_word, [39:32] word_index
   logic        rsp_tuser;               // [0] past_limit
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   lte_scrambling_sequence_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Shadow of the block: configuration, both LFSRs and the word counter
   // ---------------------------------------------------------------------------------
   logic [2:0]  cfg_kind = CH_SHARED;
   logic [7:0]  cfg_cell_group = '0;
   logic [1:0]  cfg_cell_sector = '0;
   logic [15:0] cfg_rnti = '0;
   logic        cfg_codeword = 1'b0;
   logic [7:0]  cfg_mbsfn = '0;
   logic [5:0]  cfg_lead = LEAD_IN_RESET;

   logic [30:0] gold_x1 = 31'd1;
   logic [30:0] gold_x2 = '0;
   logic [8:0]  words_out = '0;

   seq_req_type   req_backlog[$];        // requests waiting to be offered
   gold_word_type gold_words_due[$];     // words predicted, not yet seen

   int  reqs_queued   = 0;
   int  reqs_accepted = 0;
   int  fail_count    = 0;
   logic req_hs = 1'b0;                  // request taken at the last rising edge
   bit   calm = 1'b0;                    // phase with no idling on either side
   int   squeeze_ask = 0;
   int   squeeze_seen = 0;
   int   req_gap = 0;
   int   hold_left = 0;
   int   idle_cycles = 0;

   // 32 steps of both registers; bit k of the word is the k-th sequence bit
   function automatic logic [31:0] next_gold_word();
      logic [31:0] w;
      logic        fb1;
      logic        fb2;
      w = '0;
      for (int k = 0; k < 32; k++) begin
         w[k] = gold_x1[0] ^ gold_x2[0];
         fb1  = gold_x1[3] ^ gold_x1[0];
         fb2  = gold_x2[3] ^ gold_x2[2] ^ gold_x2[1] ^ gold_x2[0];
         gold_x1 = {fb1, gold_x1[30:1]};
         gold_x2 = {fb2, gold_x2[30:1]};
      end
      return w;
   endfunction

   // c_init for the current channel kind; 32-bit wrap, then cut to 31 bits
   function automatic logic [30:0] scramble_seed(input logic [3:0] n);
      logic [31:0] pci;
      logic [31:0] sf;
      logic [31:0] rnti;
      logic [31:0] v;
      pci  = 32'd3 * {24'd0, cfg_cell_group} + {30'd0, cfg_cell_sector};
      sf   = {28'd0, n};
      rnti = {16'd0, cfg_rnti};
      case (cfg_kind)
         CH_SHARED:    v = (rnti << 14) + ({31'd0, cfg_codeword} << 13) + (sf << 9) + pci;
         CH_FORMAT:    v = (((sf + 32'd1) * (32'd2 * pci + 32'd1)) << 9) + pci;
         CH_CONTROL:   v = (sf << 9) + pci;
         CH_BROADCAST: v = pci;
         CH_MULTICAST: v = (sf << 9) + {24'd0, cfg_mbsfn};
         CH_UL_CTRL:   v = (((sf + 32'd1) * (32'd2 * pci + 32'd1)) << 16) + rnti;
         default:      v = '0;      // unused kinds leave x2 all zero
      endcase
      return v[30:0];
   endfunction

   // ---------------------------------------------------------------------------------
   // Monitor: checks responses, then predicts for the request taken at this edge.
   // A response cannot belong to a request taken at the same edge (output register).
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      gold_word_type due;
      if (reset) begin
         req_hs <= 1'b0;
      end else begin
         req_hs <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (gold_words_due.size() == 0) begin
               $error("unexpected response: seq_word %h word_index %0d past_limit %b",
                      rsp_tdata[31:0], rsp_tdata[39:32], rsp_tuser);
               fail_count++;
            end else begin
               due = gold_words_due.pop_front();
               if (rsp_tdata[31:0] !== due.word) begin
                  $error("seq_word: expected %h, actual %h", due.word, rsp_tdata[31:0]);
                  fail_count++;
               end
               if (rsp_tdata[39:32] !== due.index) begin
                  $error("word_index: expected %0d, actual %0d", due.index, rsp_tdata[39:32]);
                  fail_count++;
               end
               if (rsp_tuser !== due.past) begin
                  $error("past_limit: expected %b, actual %b", due.past, rsp_tuser);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            reqs_accepted++;
            if (req_tuser == MODE_START) begin
               gold_x1   = 31'd1;
               gold_x2   = scramble_seed(req_tdata[3:0]);
               words_out = '0;
               repeat (cfg_lead) void'(next_gold_word());
            end else begin
               due.word  = next_gold_word();
               due.index = (words_out > INDEX_SAT) ? 8'(INDEX_SAT) : words_out[7:0];
               due.past  = (words_out >= MAX_WORDS);
               if (words_out < MAX_WORDS)
                  words_out++;
               gold_words_due.push_back(due);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Request driver: offers the backlog at falling edges, random gaps between requests
   // ---------------------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (calm || r < 65)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(6, 30);
   endfunction

   always @(negedge clock) begin
      seq_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_hs) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (req_backlog.size() != 0) begin
            nxt = req_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= nxt.mode;
            req_tdata  <= {4'd0, nxt.subframe};
            req_gap    = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Response sink: random stalls, occasional long ones, and on request one very long
   // hold-off so the output register fills and req_tready drops
   // ---------------------------------------------------------------------------------
   always @(negedge clock) begin
      int r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (squeeze_ask != squeeze_seen) begin
         squeeze_seen = squeeze_ask;
         hold_left    = SQUEEZE_LEN;
         rsp_tready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         r = $urandom_range(99);
         if (r < 3) begin
            hold_left   = $urandom_range(10, 40);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (r >= 25);
         end
      end
   end

   // Watchdog: nothing accepted anywhere for too long means the block has hung
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
                   (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Sequencing helpers
   // ---------------------------------------------------------------------------------
   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CHANNEL_KIND:   cfg_kind        = val[2:0];
         CSR_CELL_GROUP:     cfg_cell_group  = val[7:0];
         CSR_CELL_SECTOR:    cfg_cell_sector = val[1:0];
         CSR_RADIO_TEMP_ID:  cfg_rnti        = val;
         CSR_CODEWORD_INDEX: cfg_codeword    = val[0];
         CSR_MBSFN_AREA_ID:  cfg_mbsfn       = val[7:0];
         CSR_LEAD_IN_WORDS:  cfg_lead        = val[5:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic push_req(input logic mode, input logic [3:0] sf);
      seq_req_type q;
      q.mode = mode;
      q.subframe = sf;
      req_backlog.push_back(q);
      reqs_queued++;
   endtask

   // Block idle: every request taken, every word seen, and any lead-in run out
   task automatic settle();
      @(negedge clock);
      while (reqs_accepted != reqs_queued || gold_words_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   function automatic logic [3:0] pick_subframe();
      if ($urandom_range(99) < 80)
         return 4'($urandom_range(0, 9));
      else
         return 4'($urandom_range(0, 15));
   endfunction

   function automatic logic [7:0] pick_byte_extreme(input int top);
      int r;
      r = $urandom_range(99);
      if (r < 20)
         return 8'd0;
      else if (r < 40)
         return 8'(top);
      else
         return 8'($urandom_range(0, 255));
   endfunction

   // New random setting; narrow fields sometimes carry junk in the unused upper bits
   task automatic randomise_config();
      int r;
      logic [CSR_DATA_BITS-1:0] junk;
      junk = ($urandom_range(3) == 0) ? 16'($urandom) : 16'd0;
      write_csr(CSR_CHANNEL_KIND, {junk[15:3], 3'($urandom_range(0, 7))});
      write_csr(CSR_CELL_GROUP, {junk[15:8], pick_byte_extreme(167)});
      write_csr(CSR_CELL_SECTOR, {junk[15:2], 2'($urandom_range(0, 3))});
      r = $urandom_range(99);
      write_csr(CSR_RADIO_TEMP_ID, (r < 15) ? 16'hFFFF : (r < 30) ? 16'h0000 : 16'($urandom));
      write_csr(CSR_CODEWORD_INDEX, {junk[15:1], 1'($urandom_range(0, 1))});
      write_csr(CSR_MBSFN_AREA_ID, {junk[15:8], pick_byte_extreme(255)});
      // lead-in mostly short to keep starts quick, sometimes the extremes
      r = $urandom_range(99);
      write_csr(CSR_LEAD_IN_WORDS,
                {junk[15:6], (r < 15) ? 6'd63 : (r < 30) ? 6'd0 : 6'($urandom_range(1, 6))});
      if ($urandom_range(3) == 0)
         write_csr(CSR_UNUSED, 16'($urandom));   // no register there, must be ignored
   endtask

   // Mostly start-then-next runs; the rest lone nexts and starts left unused
   task automatic queue_random_traffic(input int count);
      int added;
      int r;
      int k;
      added = 0;
      while (added < count) begin
         r = $urandom_range(99);
         if (r < 80) begin
            k = $urandom_range(1, 12);
            push_req(MODE_START, pick_subframe());
            repeat (k) push_req(MODE_NEXT, 4'($urandom_range(0, 15)));
            added += k + 1;
         end else if (r < 90) begin
            push_req(MODE_NEXT, 4'($urandom_range(0, 15)));
            added++;
         end else begin
            push_req(MODE_START, pick_subframe());
            added++;
         end
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: next before any start runs on from the reset registers
      @(posedge clock);
      push_req(MODE_NEXT, 4'd0);
      push_req(MODE_NEXT, 4'd15);
      push_req(MODE_START, 4'd0);
      push_req(MODE_NEXT, 4'd0);
      push_req(MODE_NEXT, 4'd0);

      // Every register at its top, shared channel, longest lead-in
      settle();
      write_csr(CSR_CHANNEL_KIND, {13'd0, CH_SHARED});
      write_csr(CSR_CELL_GROUP, 16'd167);
      write_csr(CSR_CELL_SECTOR, 16'd2);
      write_csr(CSR_RADIO_TEMP_ID, 16'hFFFF);
      write_csr(CSR_CODEWORD_INDEX, 16'd1);
      write_csr(CSR_MBSFN_AREA_ID, 16'd255);
      write_csr(CSR_LEAD_IN_WORDS, 16'd63);
      @(posedge clock);
      push_req(MODE_START, 4'd9);
      push_req(MODE_NEXT, 4'd0);
      push_req(MODE_NEXT, 4'd0);
      push_req(MODE_START, 4'd15);          // out-of-range subframe used as given
      push_req(MODE_NEXT, 4'd0);

      // Each other channel kind, unused ones too; out-of-range cell id, no lead-in,
      // wide seeds on the uplink control kind get cut to 31 bits
      settle();
      write_csr(CSR_LEAD_IN_WORDS, 16'd0);
      write_csr(CSR_CELL_GROUP, 16'd255);
      write_csr(CSR_CELL_SECTOR, 16'd3);
      for (int kind = 1; kind < 8; kind++) begin
         settle();
         write_csr(CSR_CHANNEL_KIND, 16'(kind));
         @(posedge clock);
         push_req(MODE_START, 4'(kind + 8));
         push_req(MODE_NEXT, 4'd0);
      end

      // Random phases; one of them a long run past the word limit with the
      // receiver holding off long enough to stall the input side
      for (int p = 0; p < 10; p++) begin
         settle();
         randomise_config();
         @(posedge clock);
         calm = ($urandom_range(3) == 0);
         if (p == 5) begin
            calm = 1'b0;
            squeeze_ask++;
            push_req(MODE_START, pick_subframe());
            repeat (MAX_WORDS + 14) push_req(MODE_NEXT, 4'($urandom_range(0, 15)));
         end else begin
            queue_random_traffic(10);
         end
      end

      settle();
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
